@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL. Empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ rtl/pli_pkg.sv @@
package pli_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int WORD_WIDTH_DEF = 32;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [8:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [8:0]         list_length;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       init_up;
    logic       init_dn;
    logic       step_up;
    logic       step_dn;
    logic       put;
    logic       report;
    logic [1:0] code;
  } pli_cmd_t;

  typedef struct packed {
    logic is_del;
    logic ins_ok;
    logic full;
    logic del_ok;
    logic up_more;
    logic dn_more;
  } pli_stat_t;

endpackage

@@ rtl/positional_list_insert_delete.sv @@
// Ordered list of signed words with insert and delete at a 1-based position.
// A word is taken when start is high while busy is low; its result appears on
// out_word with done high for exactly one cycle and cannot be held off.
// An insert or a legal delete shifts the entries that follow the edit point,
// and a rejected word shifts none. The shift goes through the memory's single
// write port, which moves one entry per cycle while the later entries shift.
`include "assert_macros.svh"

module positional_list_insert_delete #(
  parameter int CAPACITY   = pli_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = pli_pkg::WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pli_pkg::in_word_t  in_word,
  output logic               done,
  output pli_pkg::out_word_t out_word
);
  import pli_pkg::*;

  pli_cmd_t  cmd;
  pli_stat_t stat;

  pli_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pli_datapath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .out_word (out_word)
  );

  `ASSERT_CLK(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `ASSERT_CLK(a_done_after_busy, clk, rst, done |-> $past(busy))
  `ASSERT_NEVER(a_removed_zero, clk, rst, done && (out_word.status != ST_DONE) && (out_word.removed_value != 32'sd0))

endmodule

@@ rtl/pli_ctrl.sv @@
module pli_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pli_pkg::pli_stat_t  stat,
  output pli_pkg::pli_cmd_t   cmd,
  output logic                busy
);
  import pli_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_UP    = 6'b000100,
    S_PUT   = 6'b001000,
    S_DOWN  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_del) begin
          if (!stat.ins_ok) begin
            cmd.report = 1'b1;
            cmd.code   = ST_ILLEGAL;
            state_next = S_IDLE;
          end else if (stat.full) begin
            cmd.report = 1'b1;
            cmd.code   = ST_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.init_up = 1'b1;
            state_next  = S_UP;
          end
        end else begin
          if (!stat.del_ok) begin
            cmd.report = 1'b1;
            cmd.code   = ST_ILLEGAL;
            state_next = S_IDLE;
          end else begin
            cmd.init_dn = 1'b1;
            state_next  = S_DOWN;
          end
        end
      end
      S_UP: begin
        if (stat.up_more) begin
          cmd.step_up = 1'b1;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_FIN;
      end
      S_DOWN: begin
        if (stat.dn_more) begin
          cmd.step_dn = 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.report = 1'b1;
        cmd.code   = ST_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pli_datapath.sv @@
module pli_datapath #(
  parameter int CAPACITY   = pli_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = pli_pkg::WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pli_pkg::in_word_t   in_word,
  input  pli_pkg::pli_cmd_t   cmd,
  output pli_pkg::pli_stat_t  stat,
  output logic                done,
  output pli_pkg::out_word_t  out_word
);
  import pli_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > 9) ? CW : 9) + 1;

  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic [WORD_WIDTH-1:0] rdata;

  logic                  mode_q;
  logic [8:0]            pos_q;
  logic [WORD_WIDTH-1:0] val_q;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         ptr;
  logic                  pend;
  logic                  pend_up;
  logic [AW-1:0]         pend_addr;
  logic [WORD_WIDTH-1:0] removed;

  logic [CMPW-1:0]       pos_c;
  logic [CMPW-1:0]       cnt_c;
  logic [CMPW-1:0]       ptr_c;
  logic [CMPW-1:0]       pos_m1;
  logic [CMPW-1:0]       rd_c;
  logic [AW-1:0]         pos_idx;
  logic [AW-1:0]         raddr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic                  capture;
  logic [63:0]           val_ext;
  logic signed [WORD_WIDTH-1:0] rem_s;
  logic signed [63:0]    rem_ext;
  logic [CW+8:0]         len_ext;

  assign pos_c   = CMPW'(pos_q);
  assign cnt_c   = CMPW'(count);
  assign ptr_c   = CMPW'(ptr);
  assign pos_m1  = pos_c - CMPW'(1);
  assign pos_idx = pos_m1[AW-1:0];

  assign stat.is_del  = mode_q;
  assign stat.ins_ok  = (pos_c != '0) && (pos_c <= cnt_c + CMPW'(1));
  assign stat.del_ok  = (pos_c != '0) && (pos_c <= cnt_c);
  assign stat.full    = (count == CW'(CAPACITY));
  assign stat.up_more = (ptr_c >= pos_c);
  assign stat.dn_more = (ptr < count);

  assign rd_c  = cmd.step_up ? (ptr_c - CMPW'(1)) : ptr_c;
  assign raddr = rd_c[AW-1:0];

  assign capture = pend && !pend_up && (pend_addr == pos_idx);

  always_comb begin
    we    = 1'b0;
    waddr = pos_idx;
    wdata = val_q;
    if (cmd.put) begin
      we = 1'b1;
    end else if (pend && pend_up) begin
      we    = 1'b1;
      waddr = pend_addr + AW'(1);
      wdata = rdata;
    end else if (pend && !capture) begin
      we    = 1'b1;
      waddr = pend_addr - AW'(1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign val_ext = 64'($unsigned(in_word.value));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= in_word.mode;
      pos_q  <= in_word.position;
      val_q  <= val_ext[WORD_WIDTH-1:0];
    end
    if (cmd.load) begin
      removed <= '0;
    end else if (capture) begin
      removed <= rdata;
    end
    if (cmd.init_up) begin
      ptr <= count;
    end else if (cmd.init_dn) begin
      ptr <= pos_m1[CW-1:0];
    end else if (cmd.step_up) begin
      ptr <= ptr - CW'(1);
    end else if (cmd.step_dn) begin
      ptr <= ptr + CW'(1);
    end
    pend_addr <= raddr;
    pend_up   <= cmd.step_up;
  end

  always_comb begin
    count_next = count;
    if (cmd.report && (cmd.code == ST_DONE)) begin
      count_next = mode_q ? (count - CW'(1)) : (count + CW'(1));
    end
  end

  assign rem_s   = removed;
  assign rem_ext = 64'(rem_s);
  assign len_ext = (CW + 9)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      pend  <= cmd.step_up || cmd.step_dn;
      done  <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_word.status        <= cmd.code;
      out_word.removed_value <= rem_ext[31:0];
      out_word.list_length   <= len_ext[8:0];
    end
  end

endmodule

@@ tb/list_edit_tb_pkg.sv @@
package list_edit_tb_pkg;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

endpackage

@@ tb/list_edit_checker.sv @@
module list_edit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  pli_pkg::in_word_t  in_word,
  input  logic               done,
  input  pli_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 awaiting,
  output int                 stored
);
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;
  import list_edit_tb_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;

  logic signed [31:0] slots [SLOTS];
  int                 used;
  out_word_t          outcomes [$];

  function automatic out_word_t apply_edit(in_word_t w);
    out_word_t r;
    int        p;
    r.status        = ST_DONE;
    r.removed_value = '0;
    p = int'(w.position);
    if (w.mode == MODE_INSERT) begin
      if (p < 1 || p > used + 1) begin
        r.status = ST_ILLEGAL;
      end else if (used >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        for (int k = used; k > p - 1; k--) slots[k] = slots[k - 1];
        slots[p - 1] = w.value;
        used++;
      end
    end else begin
      if (p < 1 || p > used) begin
        r.status = ST_ILLEGAL;
      end else begin
        r.removed_value = slots[p - 1];
        for (int k = p; k < used; k++) slots[k - 1] = slots[k];
        used--;
      end
    end
    r.list_length = used[8:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    awaiting   = 0;
    stored     = 0;
    used       = 0;
  end

  // Results are compared before the word accepted at the same edge is
  // predicted, so the oldest expectation always belongs to the earlier word.
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      used = 0;
      outcomes.delete();
    end else begin
      if (done) begin
        if (outcomes.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %p", $time, out_word);
          fail_count++;
        end else begin
          want = outcomes.pop_front();
          if (out_word.status !== want.status) begin
            $display("%0t ns: status expected %0d actual %0d",
                     $time, want.status, out_word.status);
            fail_count++;
          end
          if (out_word.removed_value !== want.removed_value) begin
            $display("%0t ns: removed_value expected %h actual %h",
                     $time, want.removed_value, out_word.removed_value);
            fail_count++;
          end
          if (out_word.list_length !== want.list_length) begin
            $display("%0t ns: list_length expected %0d actual %0d",
                     $time, want.list_length, out_word.list_length);
            fail_count++;
          end
        end
      end
      if (start && !busy) outcomes.push_back(apply_edit(in_word));
    end
    awaiting = outcomes.size();
    stored   = used;
  end

endmodule

@@ tb/tb_positional_list_insert_delete.sv @@
module tb_positional_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;
  import list_edit_tb_pkg::*;

  localparam int ITEM_GOAL  = 1700;
  localparam int QUIET_MAX  = 4000;
  localparam int FULL_SIZE  = CAPACITY_DEF;
  localparam int IDLE_PCT [4] = '{0, 76, 0, 29};

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      done;
  out_word_t out_word;

  int failures;
  int awaiting;
  int stored;
  int sent = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  positional_list_insert_delete dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .done     (done),
    .out_word (out_word)
  );

  list_edit_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .done       (done),
    .out_word   (out_word),
    .fail_count (failures),
    .awaiting   (awaiting),
    .stored     (stored)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic issue(logic m, int p, logic [31:0] v);
    in_word_t    w;
    int          idle;
    logic [63:0] junk;
    w.mode     = m;
    w.position = p[8:0];
    w.value    = v;
    idle = IDLE_PCT[(sent / 100) % 4];
    if ($urandom_range(99) < idle) begin
      junk = {$urandom, $urandom};
      start   <= 1'b0;
      in_word <= junk[$bits(in_word_t)-1:0];
      @(negedge clk);
      while ($urandom_range(99) < idle) @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    while (busy) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic random_edit(int ins_pct);
    logic        m;
    int          bound;
    int          p;
    int          pick;
    logic [31:0] v;
    m = ($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_DELETE;
    bound = (m == MODE_INSERT) ? stored + 1 : stored;
    if ($urandom_range(99) < 12) begin
      pick = $urandom_range(2);
      if (pick == 0) p = 0;
      else if (pick == 1) p = bound + 1;
      else p = $urandom_range(511, bound + 1);
    end else if (bound == 0) begin
      p = 1;
    end else begin
      pick = $urandom_range(9);
      if (pick < 2) p = 1;
      else if (pick < 4) p = bound;
      else p = $urandom_range(bound, 1);
    end
    case ($urandom_range(9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = 32'h0000_0000;
      3: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    issue(m, p, v);
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    in_word = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    issue(MODE_DELETE, 1, 32'h0);
    issue(MODE_DELETE, 0, 32'h0);
    issue(MODE_INSERT, 0, 32'h5);
    issue(MODE_INSERT, 2, 32'h6);
    issue(MODE_INSERT, 1, 32'h7FFF_FFFF);
    issue(MODE_INSERT, 1, 32'h8000_0000);
    issue(MODE_INSERT, 3, 32'h0);
    issue(MODE_INSERT, 2, 32'hFFFF_FFFF);
    issue(MODE_INSERT, 6, 32'h1234_5678);
    issue(MODE_INSERT, 511, 32'hFFFF_FFFF);
    issue(MODE_DELETE, 5, 32'h0);
    issue(MODE_DELETE, 511, 32'hFFFF_FFFF);
    issue(MODE_DELETE, 4, 32'hFFFF_FFFF);
    issue(MODE_DELETE, 1, 32'h0);
    issue(MODE_DELETE, 2, 32'h0);
    issue(MODE_DELETE, 1, 32'h0);
    issue(MODE_INSERT, 1, 32'h5555_5555);
    issue(MODE_INSERT, 2, 32'hAAAA_AAAA);
    issue(MODE_DELETE, 2, 32'h0);
    issue(MODE_DELETE, 1, 32'h0);

    // Each round wanders at small sizes, fills the list, pushes on it while
    // full, drains it and then keeps deleting from the empty list.
    while (sent < ITEM_GOAL) begin
      repeat (100) random_edit(50);
      while (stored < FULL_SIZE) random_edit(90);
      repeat (25) random_edit(95);
      while (stored > 0) random_edit(10);
      repeat (15) random_edit(5);
    end

    start <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
